// ----- hw/rtl/ccz_pkg.sv -----
// Shared types, opcodes and calendar helpers for the calendar clock core.
// No dependencies; imported by ccz_step and the top level.
`default_nettype none

package ccz_pkg;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // change_flags bit positions
    localparam int FLAG_SEC   = 0;
    localparam int FLAG_MIN   = 1;
    localparam int FLAG_HOUR  = 2;
    localparam int FLAG_DAY   = 3;
    localparam int FLAG_MONTH = 4;
    localparam int FLAG_YEAR  = 5;
    localparam int FLAG_LOAD  = 6;

    localparam int IN_W  = 40;
    localparam int OUT_W = 48;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_t;

    // Request payload, last field in the lowest bits.
    typedef struct packed {
        logic       pad;
        logic [5:0] load_second;
        logic [5:0] load_minute;
        logic [4:0] load_hour;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [6:0] load_year;
        logic [5:0] elapsed_seconds;
    } req_t;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [6:0] pad;
        logic [6:0] change_flags;
        logic       time_valid;
        logic [5:0] cur_second;
        logic [5:0] cur_minute;
        logic [4:0] cur_hour;
        logic [4:0] cur_day;
        logic [3:0] cur_month;
        logic [6:0] cur_year;
    } res_t;

    localparam cal_t CAL_RESET = '{year: 7'd18, month: 4'd7, day: 5'd1,
                                   hour: 5'd8, minute: 6'd0, second: 6'd0};

    // Years 2000..2099: leap exactly when the two-digit year is a multiple of 4.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        case (month)
            4'd0:    len = 5'd0;
            4'd2:    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ccz_step.sv -----
// Next-state logic of the calendar clock: tick carry chain, load saturation
// and zone shift. Purely combinational; depends on ccz_pkg.
`default_nettype none

module ccz_step
(
    input  var ccz_pkg::cal_t    cal,
    input  var logic             valid,
    input  var ccz_pkg::op_t     op,
    input  var ccz_pkg::req_t    req,
    input  var logic signed [6:0] zone,
    output ccz_pkg::cal_t        cal_next,
    output logic                 valid_next,
    output logic [6:0]           flags_next
);
    import ccz_pkg::*;

    always_comb
    begin
        cal_t       c;
        logic [5:0] secs;
        logic [6:0] ssum;
        logic [6:0] q_abs;
        logic [3:0] oh;
        logic [5:0] om;
        logic [6:0] msum;
        logic [5:0] hsum;
        logic [4:0] len;

        c          = cal;
        valid_next = valid;
        flags_next = '0;
        secs       = (req.elapsed_seconds > 6'd59) ? 6'd59 : req.elapsed_seconds;
        ssum       = {1'b0, cal.second} + {1'b0, secs};
        q_abs      = zone[6] ? 7'(-zone) : zone;
        oh         = q_abs[5:2];
        case (q_abs[1:0])
            2'd0:    om = 6'd0;
            2'd1:    om = 6'd15;
            2'd2:    om = 6'd30;
            default: om = 6'd45;
        endcase
        msum = '0;
        hsum = '0;
        len  = '0;

        if (op == OP_TICK)
        begin
            if (valid && secs != 6'd0)
            begin
                flags_next[FLAG_SEC] = 1'b1;
                if (ssum < 7'd60)
                begin
                    c.second = ssum[5:0];
                end
                else
                begin
                    c.second = 6'(ssum - 7'd60);
                    flags_next[FLAG_MIN] = 1'b1;
                    if (cal.minute < 6'd59)
                    begin
                        c.minute = cal.minute + 6'd1;
                    end
                    else
                    begin
                        c.minute = '0;
                        flags_next[FLAG_HOUR] = 1'b1;
                        if (cal.hour < 5'd23)
                        begin
                            c.hour = cal.hour + 5'd1;
                        end
                        else
                        begin
                            c.hour = '0;
                            flags_next[FLAG_DAY] = 1'b1;
                            if ({1'b0, cal.day} + 6'd1 <= {1'b0, days_in(cal.month, cal.year)})
                            begin
                                c.day = cal.day + 5'd1;
                            end
                            else
                            begin
                                c.day = 5'd1;
                                flags_next[FLAG_MONTH] = 1'b1;
                                if (cal.month < 4'd12)
                                begin
                                    c.month = cal.month + 4'd1;
                                end
                                else
                                begin
                                    c.month = 4'd1;
                                    flags_next[FLAG_YEAR] = 1'b1;
                                    c.year = (cal.year >= 7'd99) ? 7'd0 : cal.year + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            // saturate the UTC fields into range
            c.year   = (req.load_year > 7'd99) ? 7'd99 : req.load_year;
            c.month  = (req.load_month == 4'd0) ? 4'd1 :
                       (req.load_month > 4'd12) ? 4'd12 : req.load_month;
            len      = days_in(c.month, c.year);
            c.day    = (req.load_day == 5'd0) ? 5'd1 :
                       (req.load_day > len) ? len : req.load_day;
            c.hour   = (req.load_hour > 5'd23) ? 5'd23 : req.load_hour;
            c.minute = (req.load_minute > 6'd59) ? 6'd59 : req.load_minute;
            c.second = (req.load_second > 6'd59) ? 6'd59 : req.load_second;

            // shift by the zone offset; offsets beyond 12 h are dropped
            if (q_abs != 7'd0 && q_abs <= 7'd48)
            begin
                if (!zone[6])
                begin
                    msum = {1'b0, c.minute} + {1'b0, om};
                    if (msum > 7'd59)
                    begin
                        oh       = oh + 4'd1;
                        c.minute = 6'(msum - 7'd60);
                    end
                    else
                    begin
                        c.minute = msum[5:0];
                    end
                    hsum = {1'b0, c.hour} + {2'b0, oh};
                    if (hsum > 6'd23)
                    begin
                        c.hour = 5'(hsum - 6'd24);
                        // roll over from the last day before the 5-bit day can wrap
                        if (c.day >= days_in(c.month, c.year))
                        begin
                            c.day   = 5'd1;
                            c.month = c.month + 4'd1;
                            if (c.month > 4'd12)
                            begin
                                c.month = 4'd1;
                                c.year  = (c.year >= 7'd99) ? 7'd0 : c.year + 7'd1;
                            end
                        end
                        else
                        begin
                            c.day = c.day + 5'd1;
                        end
                    end
                    else
                    begin
                        c.hour = hsum[4:0];
                    end
                end
                else
                begin
                    if (om > c.minute)
                    begin
                        oh       = oh + 4'd1;
                        c.minute = 6'(7'd60 + {1'b0, c.minute} - {1'b0, om});
                    end
                    else
                    begin
                        c.minute = c.minute - om;
                    end
                    if ({1'b0, oh} > c.hour)
                    begin
                        c.hour = 5'(6'd24 + {1'b0, c.hour} - {2'b0, oh});
                        c.day  = c.day - 5'd1;
                        if (c.day == 5'd0)
                        begin
                            c.month = c.month - 4'd1;
                            if (c.month == 4'd0)
                            begin
                                c.year  = (c.year == 7'd0) ? 7'd99 : c.year - 7'd1;
                                c.month = 4'd12;
                                c.day   = 5'd31;
                            end
                            else
                            begin
                                c.day = days_in(c.month, c.year);
                            end
                        end
                    end
                    else
                    begin
                        c.hour = c.hour - 5'(oh);
                    end
                end
            end
            valid_next             = 1'b1;
            flags_next[FLAG_LOAD]  = 1'b1;
        end

        cal_next = c;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/calendar_clock_with_zone_offset_core.sv -----
// Calendar clock with zone offset: request register, combinational step, result register.
// A request passes from the request register through the step to the result register.
// Throughput: one request per cycle unless m_axis_tready stalls; ccz_step, the single
// combinational step, updates the clock as each request enters the result register.
// Reset: clock at 2018-07-01 08:00:00, not valid, zone offset 0, both stages empty.
`default_nettype none

module calendar_clock_with_zone_offset_core
(
    input  var logic                      clk,
    input  var logic                      rst_n,
    input  var logic                      cfg_we,
    input  var logic [6:0]                cfg_wdata,   // zone_quarter_hours
    input  var logic                      s_axis_tvalid,
    output logic                          s_axis_tready,
    // elapsed_seconds, load_year, load_month, load_day, load_hour,
    // load_minute, load_second, zero pad
    input  var logic [ccz_pkg::IN_W-1:0]  s_axis_tdata,
    input  var logic                      s_axis_tuser, // opcode
    output logic                          m_axis_tvalid,
    input  var logic                      m_axis_tready,
    // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
    // time_valid, change_flags, zero pad
    output logic [ccz_pkg::OUT_W-1:0]     m_axis_tdata
);
    import ccz_pkg::*;

    logic              in_valid_reg;
    op_t               in_op_reg;
    req_t              in_req_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;
    cal_t              cal_reg;
    logic              valid_reg;
    logic signed [6:0] zone_reg;

    cal_t              cal_next;
    logic              valid_next;
    logic [6:0]        flags_next;
    logic              advance;
    res_t              res_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg;

    ccz_step u_step
    (
        .cal        (cal_reg),
        .valid      (valid_reg),
        .op         (in_op_reg),
        .req        (in_req_reg),
        .zone       (zone_reg),
        .cal_next   (cal_next),
        .valid_next (valid_next),
        .flags_next (flags_next)
    );

    always_comb
    begin
        res_next              = '0;
        res_next.cur_year     = cal_next.year;
        res_next.cur_month    = cal_next.month;
        res_next.cur_day      = cal_next.day;
        res_next.cur_hour     = cal_next.hour;
        res_next.cur_minute   = cal_next.minute;
        res_next.cur_second   = cal_next.second;
        res_next.time_valid   = valid_next;
        res_next.change_flags = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_reg       <= CAL_RESET;
            valid_reg     <= 1'b0;
            zone_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                zone_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                cal_reg   <= cal_next;
                valid_reg <= valid_next;
            end
            // hold the result until it is taken
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg  <= op_t'(s_axis_tuser);
            in_req_reg <= req_t'(s_axis_tdata);
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    // once loaded, the clock never drops back to invalid
    assert property (@(posedge clk) disable iff (!rst_n) valid_reg |=> valid_reg)
        else $error("clock valid flag dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == OP_LOAD) |=> (valid_reg && out_res_reg.time_valid))
        else $error("load did not set the clock valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg.second <= 6'd59 && cal_reg.minute <= 6'd59 && cal_reg.hour <= 5'd23
        && cal_reg.month >= 4'd1 && cal_reg.month <= 4'd12 && cal_reg.year <= 7'd99)
        else $error("clock field out of range");

    // a carry into a field implies every lower field changed as well
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_res_reg.change_flags[5:1]
                            & ~out_res_reg.change_flags[4:0]) == 5'd0))
        else $error("broken carry chain in change flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.time_valid) |-> (out_res_reg.change_flags == 7'd0))
        else $error("change reported while clock invalid");

endmodule

`default_nettype wire
